// ===== hdl/joystick_calibrate_deadzone_smooth_assert.svh =====
// assertion macros shared by the joystick front end
`ifndef JOYSTICK_CALIBRATE_DEADZONE_SMOOTH_ASSERT_SVH
`define JOYSTICK_CALIBRATE_DEADZONE_SMOOTH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JCDS_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define JCDS_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== hdl/jcds_pkg.sv =====
package jcds_pkg;

	localparam int ADC_BITS_DEF       = 12;
	localparam int WINDOW_SAMPLES_DEF = 24;
	localparam int MAX_ATTEMPTS_DEF   = 5;

	localparam int Q_W     = 16;
	localparam int Q15_MAX = 32767;
	localparam int CMP_W   = 16;

	localparam int DZ_W     = 11;
	localparam int ALPHA_W  = 16;
	localparam int SPREAD_W = 12;

	localparam logic [DZ_W-1:0]     DEADZONE_RST = 11'd205;
	localparam logic [ALPHA_W-1:0]  ALPHA_RST    = 16'd22938;
	localparam logic [SPREAD_W-1:0] SPREAD_RST   = 12'd40;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD   = 2'd2;

	localparam int MUL_W  = 17;
	localparam int PROD_W = 2 * MUL_W;

	typedef logic signed [Q_W-1:0]   q15_t;
	typedef logic signed [MUL_W-1:0] mul_op_t;

endpackage

// ===== hdl/jcds_ifs.sv =====
interface jcds_sample_if #(parameter int ADC_BITS = jcds_pkg::ADC_BITS_DEF) ();
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] x_sample;
	logic [ADC_BITS-1:0] y_sample;

	modport source (output valid, output x_sample, output y_sample, input ready);
	modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

interface jcds_result_if #(parameter int ADC_BITS = jcds_pkg::ADC_BITS_DEF) ();
	import jcds_pkg::*;

	logic                valid;
	logic                ready;
	q15_t                x_out;
	q15_t                y_out;
	logic                calibrating;
	logic [ADC_BITS-1:0] center_x_out;
	logic [ADC_BITS-1:0] center_y_out;
	logic                cal_settled;

	modport source (output valid, output x_out, output y_out, output calibrating,
		output center_x_out, output center_y_out, output cal_settled, input ready);
	modport sink (input valid, input x_out, input y_out, input calibrating,
		input center_x_out, input center_y_out, input cal_settled, output ready);
endinterface

// ===== hdl/joystick_calibrate_deadzone_smooth.sv =====
// Joystick front end: rest-center calibration, deadzone, Q1.15 scaling and smoothing.
// samples (sink): paired raw ADC readings x_sample / y_sample, one item per handshake.
// results (source): one result item per accepted sample item, in order.
// cfg_we / cfg_index / cfg_wdata: register writes (deadzone, alpha, settle spread),
// taken at any edge with cfg_we high; the user writes only while no item is in flight,
// which the block itself does not enforce.
// Throughput: samples.ready is high only while the sequencer is idle, so a new item is
// taken only after the last one has left the write-out step. A calibration item goes
// straight to the write-out step, through a window check when it closes a window; a
// tracking item makes four passes through the single shared 17x17 multiplier (scale x,
// scale y, smooth x, smooth y). The item that closes the last window also waits for a
// median search that ranks every stored sample against the whole window, one read of
// the window memory per cycle.
// Stall: the output register holds one finished item; the next item may be
// accepted and worked while it waits, and the sequencer holds at the write-out
// step until the receiver takes the pending item.
// Reset: calibration restarts, centers return to mid-scale, smoothing state is
// zero, registers take their reset values; no memory clearing pass is needed.
module joystick_calibrate_deadzone_smooth #(
	parameter int WINDOW_SAMPLES = jcds_pkg::WINDOW_SAMPLES_DEF,
	parameter int MAX_ATTEMPTS   = jcds_pkg::MAX_ATTEMPTS_DEF,
	parameter int ADC_BITS       = jcds_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	jcds_sample_if.sink                       samples,
	jcds_result_if.source                     results,
	input  logic                              cfg_we,
	input  logic [jcds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jcds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	import jcds_pkg::*;
	`include "joystick_calibrate_deadzone_smooth_assert.svh"

	localparam int M       = ADC_BITS - 1;
	localparam int H_C     = (1 << M) - 1;
	localparam int A_C     = Q15_MAX / H_C;
	localparam int B_C     = Q15_MAX % H_C;
	localparam int FILL_W  = $clog2(WINDOW_SAMPLES);
	localparam int AT_W    = $clog2(MAX_ATTEMPTS + 1);
	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	localparam int ADC_MID = 1 << (ADC_BITS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MX   = 4'd1;
	localparam logic [3:0] S_MY   = 4'd2;
	localparam logic [3:0] S_AX   = 4'd3;
	localparam logic [3:0] S_AY   = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_MED  = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;

	logic [3:0]            state_q;
	logic                  accept;
	logic                  load;

	logic [DZ_W-1:0]       dz_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic [SPREAD_W-1:0]   spread_q;

	logic [ADC_BITS-1:0]   xs_q;
	logic [ADC_BITS-1:0]   ys_q;
	logic [ADC_BITS-1:0]   min_x_q;
	logic [ADC_BITS-1:0]   max_x_q;
	logic [ADC_BITS-1:0]   min_y_q;
	logic [ADC_BITS-1:0]   max_y_q;
	logic [FILL_W-1:0]     fill_q;
	logic [AT_W-1:0]       attempt_q;
	logic [AT_W-1:0]       att_nx;
	logic                  cal_active_q;
	logic                  settled_q;
	logic                  run_item_q;
	logic [ADC_BITS-1:0]   center_x_q;
	logic [ADC_BITS-1:0]   center_y_q;
	q15_t                  sx_q;
	q15_t                  sy_q;
	q15_t                  vx_q;
	q15_t                  vy_q;

	logic                  settled;
	logic                  last_win;
	logic [ADC_BITS-1:0]   spx;
	logic [ADC_BITS-1:0]   spy;

	logic [ADC_BITS:0]     dx;
	logic [ADC_BITS:0]     dy;
	logic [ADC_BITS:0]     dxn;
	logic [ADC_BITS:0]     dyn;
	logic [ADC_BITS-1:0]   mag_x;
	logic [ADC_BITS-1:0]   mag_y;
	logic [ADC_BITS-1:0]   mag_v;
	logic                  neg_v;

	logic [2*M-1:0]        y_w;
	logic [M-1:0]          q0;
	logic [M:0]            r_w;
	logic [M-1:0]          q1;
	logic [Q_W-2:0]        vmag;
	q15_t                  v_scaled;

	mul_op_t               op_a;
	mul_op_t               op_b;
	logic                  mul_en;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-Q_W-1:0] inc;
	logic signed [PROD_W-Q_W-1:0] sx_sum;
	logic signed [PROD_W-Q_W-1:0] sy_sum;
	q15_t                  sy_nx;

	logic                  med_start;
	logic                  med_done;
	logic [ADC_BITS-1:0]   med_x;
	logic [ADC_BITS-1:0]   med_y;

	logic                  out_valid_q;
	q15_t                  x_out_q;
	q15_t                  y_out_q;
	logic                  calib_out_q;
	logic [ADC_BITS-1:0]   cx_out_q;
	logic [ADC_BITS-1:0]   cy_out_q;
	logic                  settled_out_q;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && (state_q == S_IDLE);
	assign load          = (state_q == S_OUT) && (!out_valid_q || results.ready);

	// offsets from the centers
	always_comb begin
		dx    = {1'b0, xs_q} - {1'b0, center_x_q};
		dy    = {1'b0, ys_q} - {1'b0, center_y_q};
		dxn   = -dx;
		dyn   = -dy;
		mag_x = dx[ADC_BITS] ? dxn[ADC_BITS-1:0] : dx[ADC_BITS-1:0];
		mag_y = dy[ADC_BITS] ? dyn[ADC_BITS-1:0] : dy[ADC_BITS-1:0];
		mag_v = (state_q == S_MY) ? mag_x : mag_y;
		neg_v = (state_q == S_MY) ? dx[ADC_BITS] : dy[ADC_BITS];
	end

	// d*32767/H as A*|d| + floor(B*|d|/H), H = 2^M-1 by end-around fold
	always_comb begin
		y_w  = prod_q[2*M-1:0];
		q0   = y_w[2*M-1:M];
		r_w  = {1'b0, y_w[M-1:0]} + {1'b0, q0};
		q1   = q0 + M'(r_w >= (M+1)'(H_C));
		if (mag_v > ADC_BITS'(H_C)) begin
			vmag = (Q_W-1)'(Q15_MAX);
		end else begin
			vmag = (Q_W-1)'(A_C * mag_v[M-1:0]) + (Q_W-1)'(q1);
		end
		if (CMP_W'(mag_v) < CMP_W'(dz_q)) begin
			vmag = '0;
		end
		v_scaled = neg_v ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
	end

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		mul_en = 1'b0;
		case (state_q)
			S_MX: begin
				op_a   = MUL_W'(B_C);
				op_b   = MUL_W'(mag_x[M-1:0]);
				mul_en = 1'b1;
			end
			S_MY: begin
				op_a   = MUL_W'(B_C);
				op_b   = MUL_W'(mag_y[M-1:0]);
				mul_en = 1'b1;
			end
			S_AX: begin
				op_a   = {vx_q[Q_W-1], vx_q} - {sx_q[Q_W-1], sx_q};
				op_b   = {1'b0, alpha_q};
				mul_en = 1'b1;
			end
			S_AY: begin
				op_a   = {vy_q[Q_W-1], vy_q} - {sy_q[Q_W-1], sy_q};
				op_b   = {1'b0, alpha_q};
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	jcds_mul #(.W(MUL_W)) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (op_a),
		.b   (op_b),
		.p_q (prod_q)
	);

	// floor of product / 65536
	always_comb begin
		inc    = prod_q[PROD_W-1:Q_W];
		sx_sum = {{(PROD_W-2*Q_W){sx_q[Q_W-1]}}, sx_q} + inc;
		sy_sum = {{(PROD_W-2*Q_W){sy_q[Q_W-1]}}, sy_q} + inc;
		sy_nx  = run_item_q ? sy_sum[Q_W-1:0] : sy_q;
	end

	always_comb begin
		spx      = max_x_q - min_x_q;
		spy      = max_y_q - min_y_q;
		settled  = (CMP_W'(spx) <= CMP_W'(spread_q)) && (CMP_W'(spy) <= CMP_W'(spread_q));
		att_nx   = attempt_q + 1'b1;
		last_win = settled || (att_nx >= AT_W'(MAX_ATTEMPTS));
	end

	assign med_start = (state_q == S_CHK) && last_win;

	jcds_median #(
		.WINDOW_SAMPLES (WINDOW_SAMPLES),
		.ADC_BITS       (ADC_BITS)
	) u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && cal_active_q),
		.wr_addr (fill_q),
		.wr_x    (samples.x_sample),
		.wr_y    (samples.y_sample),
		.start   (med_start),
		.done    (med_done),
		.med_x   (med_x),
		.med_y   (med_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q     <= DEADZONE_RST;
			alpha_q  <= ALPHA_RST;
			spread_q <= SPREAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEADZONE: dz_q     <= cfg_wdata[DZ_W-1:0];
				REG_ALPHA:    alpha_q  <= cfg_wdata[ALPHA_W-1:0];
				REG_SPREAD:   spread_q <= cfg_wdata[SPREAD_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q <= samples.x_sample;
			ys_q <= samples.y_sample;
		end
		if (state_q == S_MY) begin
			vx_q <= v_scaled;
		end
		if (state_q == S_AX) begin
			vy_q <= v_scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			min_x_q      <= ADC_BITS'(ADC_MAX);
			max_x_q      <= '0;
			min_y_q      <= ADC_BITS'(ADC_MAX);
			max_y_q      <= '0;
			fill_q       <= '0;
			attempt_q    <= '0;
			cal_active_q <= 1'b1;
			settled_q    <= 1'b0;
			run_item_q   <= 1'b0;
			center_x_q   <= ADC_BITS'(ADC_MID);
			center_y_q   <= ADC_BITS'(ADC_MID);
			sx_q         <= '0;
			sy_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						run_item_q <= !cal_active_q;
						if (cal_active_q) begin
							if (samples.x_sample < min_x_q) min_x_q <= samples.x_sample;
							if (samples.x_sample > max_x_q) max_x_q <= samples.x_sample;
							if (samples.y_sample < min_y_q) min_y_q <= samples.y_sample;
							if (samples.y_sample > max_y_q) max_y_q <= samples.y_sample;
							if (fill_q == FILL_W'(WINDOW_SAMPLES - 1)) begin
								state_q <= S_CHK;
							end else begin
								fill_q  <= fill_q + 1'b1;
								state_q <= S_OUT;
							end
						end else begin
							state_q <= S_MX;
						end
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_AX;
				S_AX: state_q <= S_AY;
				S_AY: begin
					sx_q    <= sx_sum[Q_W-1:0];
					state_q <= S_OUT;
				end
				S_CHK: begin
					attempt_q <= att_nx;
					if (last_win) begin
						settled_q <= settled;
						state_q   <= S_MED;
					end else begin
						min_x_q <= ADC_BITS'(ADC_MAX);
						max_x_q <= '0;
						min_y_q <= ADC_BITS'(ADC_MAX);
						max_y_q <= '0;
						fill_q  <= '0;
						state_q <= S_OUT;
					end
				end
				S_MED: begin
					if (med_done) begin
						center_x_q   <= med_x;
						center_y_q   <= med_y;
						cal_active_q <= 1'b0;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (load) begin
						sy_q    <= sy_nx;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_out_q       <= cal_active_q ? '0 : sx_q;
			y_out_q       <= cal_active_q ? '0 : sy_nx;
			calib_out_q   <= cal_active_q;
			cx_out_q      <= center_x_q;
			cy_out_q      <= center_y_q;
			settled_out_q <= settled_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.x_out        = x_out_q;
	assign results.y_out        = y_out_q;
	assign results.calibrating  = calib_out_q;
	assign results.center_x_out = cx_out_q;
	assign results.center_y_out = cy_out_q;
	assign results.cal_settled  = settled_out_q;

	`JCDS_ASSERT_NEXT(a_cal_done_sticks, !cal_active_q, !cal_active_q, "calibration restarted")
	`JCDS_ASSERT_NOW(a_smooth_zero_in_cal, cal_active_q, (sx_q == '0) && (sy_q == '0), "smoothing moved during calibration")
	`JCDS_ASSERT_NOW(a_attempt_bound, 1'b1, attempt_q <= AT_W'(MAX_ATTEMPTS), "attempt count overran")
	`JCDS_ASSERT_NOW(a_med_done_in_med, med_done, state_q == S_MED, "median finished outside search")

endmodule

// ===== hdl/jcds_mul.sv =====
module jcds_mul #(
	parameter int W = jcds_pkg::MUL_W
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// ===== hdl/jcds_median.sv =====
module jcds_median #(
	parameter int WINDOW_SAMPLES = jcds_pkg::WINDOW_SAMPLES_DEF,
	parameter int ADC_BITS       = jcds_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [$clog2(WINDOW_SAMPLES)-1:0] wr_addr,
	input  logic [ADC_BITS-1:0]               wr_x,
	input  logic [ADC_BITS-1:0]               wr_y,
	input  logic                              start,
	output logic                              done,
	output logic [ADC_BITS-1:0]               med_x,
	output logic [ADC_BITS-1:0]               med_y
);

	localparam int IDX_W = $clog2(WINDOW_SAMPLES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);
	localparam logic [IDX_W-1:0] MED_RANK = IDX_W'(WINDOW_SAMPLES / 2);

	logic [ADC_BITS-1:0] mem_x [WINDOW_SAMPLES];
	logic [ADC_BITS-1:0] mem_y [WINDOW_SAMPLES];

	logic                busy_q;
	logic                issuing_q;
	logic                cmp_phase_q;
	logic [IDX_W-1:0]    ci_q;
	logic [IDX_W-1:0]    cj_q;
	logic [IDX_W-1:0]    rd_addr;

	logic                tag_v_s1;
	logic                tag_cmp_s1;
	logic                tag_last_s1;
	logic                tag_end_s1;
	logic [IDX_W-1:0]    tag_idx_s1;
	logic [ADC_BITS-1:0] rdx_s1;
	logic [ADC_BITS-1:0] rdy_s1;

	logic [ADC_BITS-1:0] cand_x_q;
	logic [ADC_BITS-1:0] cand_y_q;
	logic [IDX_W-1:0]    cand_idx_q;
	logic [IDX_W-1:0]    rank_x_q;
	logic [IDX_W-1:0]    rank_y_q;
	logic [IDX_W-1:0]    rank_x_nx;
	logic [IDX_W-1:0]    rank_y_nx;
	logic                inc_x;
	logic                inc_y;
	logic                done_q;
	logic [ADC_BITS-1:0] med_x_q;
	logic [ADC_BITS-1:0] med_y_q;

	assign rd_addr = cmp_phase_q ? cj_q : ci_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
		rdx_s1 <= mem_x[rd_addr];
		rdy_s1 <= mem_y[rd_addr];
	end

	// rank with ties broken by position
	always_comb begin
		inc_x = (rdx_s1 < cand_x_q) || ((rdx_s1 == cand_x_q) && (tag_idx_s1 < cand_idx_q));
		inc_y = (rdy_s1 < cand_y_q) || ((rdy_s1 == cand_y_q) && (tag_idx_s1 < cand_idx_q));
		rank_x_nx = rank_x_q + IDX_W'(inc_x);
		rank_y_nx = rank_y_q + IDX_W'(inc_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			issuing_q   <= 1'b0;
			cmp_phase_q <= 1'b0;
			ci_q        <= '0;
			cj_q        <= '0;
			tag_v_s1    <= 1'b0;
			tag_cmp_s1  <= 1'b0;
			tag_last_s1 <= 1'b0;
			tag_end_s1  <= 1'b0;
			tag_idx_s1  <= '0;
			done_q      <= 1'b0;
		end else begin
			tag_v_s1    <= busy_q && issuing_q;
			tag_cmp_s1  <= cmp_phase_q;
			tag_idx_s1  <= rd_addr;
			tag_last_s1 <= cmp_phase_q && (cj_q == LAST_IDX);
			tag_end_s1  <= cmp_phase_q && (cj_q == LAST_IDX) && (ci_q == LAST_IDX);
			done_q      <= tag_v_s1 && tag_cmp_s1 && tag_end_s1;

			if (start && !busy_q) begin
				busy_q      <= 1'b1;
				issuing_q   <= 1'b1;
				cmp_phase_q <= 1'b0;
				ci_q        <= '0;
				cj_q        <= '0;
			end else if (busy_q && issuing_q) begin
				if (!cmp_phase_q) begin
					cmp_phase_q <= 1'b1;
					cj_q        <= '0;
				end else if (cj_q == LAST_IDX) begin
					cmp_phase_q <= 1'b0;
					if (ci_q == LAST_IDX) begin
						issuing_q <= 1'b0;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end else begin
					cj_q <= cj_q + 1'b1;
				end
			end

			if (tag_v_s1 && tag_cmp_s1 && tag_end_s1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag_v_s1 && !tag_cmp_s1) begin
			cand_x_q   <= rdx_s1;
			cand_y_q   <= rdy_s1;
			cand_idx_q <= tag_idx_s1;
			rank_x_q   <= '0;
			rank_y_q   <= '0;
		end else if (tag_v_s1) begin
			rank_x_q <= rank_x_nx;
			rank_y_q <= rank_y_nx;
			if (tag_last_s1 && (rank_x_nx == MED_RANK)) begin
				med_x_q <= cand_x_q;
			end
			if (tag_last_s1 && (rank_y_nx == MED_RANK)) begin
				med_y_q <= cand_y_q;
			end
		end
	end

	assign done  = done_q;
	assign med_x = med_x_q;
	assign med_y = med_y_q;

endmodule
